### hw/rtl/u8u2_pkg.sv
// Shared types and byte-class constants for the UTF-8 to UCS-2 stream decoder.
// Used by u8u2_decode, u8u2_outbuf and utf8_to_ucs2_stream_decoder; no dependencies.
`default_nettype none

package u8u2_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned HOLD_N  = 2;
    localparam int unsigned MAX_RES = 3;

    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD_MASK  = 8'hE0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    typedef logic [HOLD_N-1:0][BYTE_W-1:0]  held_t;
    typedef logic [MAX_RES-1:0][UNIT_W-1:0] units_t;

    // Outcome of decoding one input byte against the held bytes.
    typedef struct packed {
        units_t      units;
        logic [1:0]  count;
        logic        done;
        held_t       held;
        logic [1:0]  held_count;
    } dec_res_t;

endpackage : u8u2_pkg

`default_nettype wire

### hw/rtl/u8u2_decode.sv
// Combinational decode of one byte together with up to two held bytes.
// Depends on u8u2_pkg.
`default_nettype none

module u8u2_decode
    import u8u2_pkg::*;
(
    input  wire held_t            held_bytes,
    input  wire logic [1:0]       held_count,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_string,
    output dec_res_t              res
);

    logic [2:0][7:0] bytes_v;
    logic [1:0]      cnt;
    logic [1:0]      n;
    logic [1:0]      pos;
    logic [1:0]      rem;
    logic [1:0]      need;
    logic [1:0]      k;
    logic            stop;
    logic            ok;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [15:0]     unit;

    always_comb begin
        cnt = (held_count == 2'd3) ? 2'd2 : held_count;
        bytes_v = '0;
        unique case (cnt)
            2'd0: bytes_v[0] = in_byte;
            2'd1: begin
                bytes_v[0] = held_bytes[0];
                bytes_v[1] = in_byte;
            end
            default: begin
                bytes_v[0] = held_bytes[0];
                bytes_v[1] = held_bytes[1];
                bytes_v[2] = in_byte;
            end
        endcase
        n    = 2'(cnt + 2'd1);
        pos  = '0;
        k    = '0;
        stop = 1'b0;
        res  = '0;
        b0   = '0;
        b1   = '0;
        b2   = '0;
        rem  = '0;
        need = '0;
        ok   = 1'b0;
        unit = '0;

        // At most three positions to resolve, one byte or one sequence per step.
        for (int it = 0; it < 3; it++) begin
            if (!stop && (pos < n)) begin
                b0   = bytes_v[pos];
                b1   = (pos == 2'd0) ? bytes_v[1] : bytes_v[2];
                b2   = bytes_v[2];
                rem  = 2'(n - pos);
                unit = {8'h00, b0};
                if ((b0 & LEAD_MASK) == LEAD3_CODE) begin
                    need = 2'd3;
                end else if ((b0 & LEAD_MASK) == LEAD2_CODE) begin
                    need = 2'd2;
                end else begin
                    need = 2'd1;
                end
                ok = ((rem < 2'd2) || ((b1 & CONT_MASK) == CONT_CODE))
                  && ((need != 2'd3) || (rem < 2'd3) || ((b2 & CONT_MASK) == CONT_CODE));

                if (((b0 & ASCII_MASK) == 8'h00) || (need == 2'd1) || !ok) begin
                    res.units[k] = unit;
                    k   = 2'(k + 2'd1);
                    pos = 2'(pos + 2'd1);
                end else if (rem >= need) begin
                    if (need == 2'd3) begin
                        unit = {b0[3:0] & LEAD3_BITS[3:0], b1[5:0] & CONT_BITS[5:0],
                                b2[5:0] & CONT_BITS[5:0]};
                    end else begin
                        unit = {5'b00000, b0[4:0] & LEAD2_BITS[4:0],
                                b1[5:0] & CONT_BITS[5:0]};
                    end
                    res.units[k] = unit;
                    k   = 2'(k + 2'd1);
                    pos = 2'(pos + need);
                end else if (end_of_string) begin
                    res.units[k] = unit;
                    k   = 2'(k + 2'd1);
                    pos = 2'(pos + 2'd1);
                end else begin
                    // Valid but unfinished prefix: keep it for the next beat.
                    res.held[0]    = b0;
                    res.held[1]    = (rem > 2'd1) ? b1 : 8'h00;
                    res.held_count = rem;
                    stop = 1'b1;
                end
            end
        end
        res.count = k;
        res.done  = end_of_string;
    end

endmodule : u8u2_decode

`default_nettype wire

### hw/rtl/u8u2_outbuf.sv
// Result register holding the code units of one input beat and handing them out one a cycle while m_tready is high.
// Depends on u8u2_pkg.
`default_nettype none

module u8u2_outbuf
    import u8u2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire dec_res_t    res,
    output logic             can_load,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // code_unit[15:0]
    output logic             m_tlast,
    output logic [0:0]       m_tuser   // string_done[0]
);

    units_t     units_reg;
    logic [1:0] rem_reg;
    logic       done_reg;
    logic       pop;

    assign m_tvalid = (rem_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign can_load = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready);
    assign m_tdata  = units_reg[0];
    assign m_tlast  = (rem_reg == 2'd1);
    assign m_tuser  = done_reg && (rem_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            done_reg <= 1'b0;
        end else if (load) begin
            rem_reg  <= res.count;
            done_reg <= res.done;
        end else if (pop) begin
            rem_reg  <= 2'(rem_reg - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            units_reg <= res.units;
        end else if (pop) begin
            units_reg[0] <= units_reg[1];
            units_reg[1] <= units_reg[2];
        end
    end

endmodule : u8u2_outbuf

`default_nettype wire

### hw/rtl/utf8_to_ucs2_stream_decoder.sv
// UTF-8 to UCS-2 stream decoder top level; depends on u8u2_pkg, u8u2_decode and u8u2_outbuf.
// Path: an accepted byte is registered in the input register and decoded combinationally there;
// its code units are registered in the result buffer that drives m_*, which can stall the input.
// Throughput: one input byte per cycle while m_tready is high and each byte yields at most one
// code unit; a byte that releases more units holds the result buffer and intake until they drain.
// Reset: aresetn is synchronous and active low; it empties both registers and clears held bytes.
`default_nettype none

module utf8_to_ucs2_stream_decoder
    import u8u2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // code_unit[15:0]
    output logic             m_tlast,   // run_last
    output logic [0:0]       m_tuser    // string_done[0]
);

    // Input register: one byte waiting to be decoded.
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    // Bytes of an unfinished multi-byte sequence.
    held_t      held_bytes_reg;
    logic [1:0] held_count_reg;

    dec_res_t   res;
    logic       can_load;
    logic       advance;

    // The held byte beat is committed when the result buffer can take all of its units.
    assign advance  = a_valid_reg && can_load;
    assign s_tready = !a_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                a_valid_reg <= 1'b1;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
            if (advance) begin
                held_bytes_reg <= res.held;
                held_count_reg <= res.held_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_byte_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
    end

    u8u2_decode u_decode (
        .held_bytes    (held_bytes_reg),
        .held_count    (held_count_reg),
        .in_byte       (a_byte_reg),
        .end_of_string (a_last_reg),
        .res           (res)
    );

    // A byte with no units loads an empty buffer, which simply stays empty.
    u8u2_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // The end of a string always leaves nothing held.
    a_end_clears_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && a_last_reg) |=> (held_count_reg == 2'd0))
        else $error("held bytes survive the end of a string");

    // A byte waiting in the input register is not overwritten before it is decoded.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !advance) |=> (a_valid_reg && $stable(a_byte_reg)))
        else $error("pending input byte lost");

    // The end-of-string mark only ever sits on the last unit of a beat.
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("string_done without run_last");
`endif

endmodule : utf8_to_ucs2_stream_decoder

`default_nettype wire
